@@ design/waypoint_travel_time_accumulator_assert.svh @@
// Assertion macros for the waypoint travel time accumulator.
`ifndef WAYPOINT_TRAVEL_TIME_ACCUMULATOR_ASSERT_SVH
`define WAYPOINT_TRAVEL_TIME_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTH
`define WTTA_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define WTTA_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`else
`define WTTA_ASSERT_IMPL(label, clk, rst_n, prop)
`define WTTA_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ design/wtta_pkg.sv @@
// Package with types and constants for the waypoint travel time accumulator.
package wtta_pkg;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TIME_WIDTH_DEF = 48;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PUSH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SQ, ST_ROOT, ST_CORDIC, ST_MUL, ST_ACC, ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic [1:0] op;
	} alu_ctl_t;

	localparam logic [1:0] OP_ROOT = 2'd0;
	localparam logic [1:0] OP_CORDIC = 2'd1;

	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E; 5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4; 5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55; 5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction
endpackage

@@ design/wtta_sqrt.sv @@
// Bit-serial integer square root of a 65-bit value, one result bit per cycle.
module wtta_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [64:0] radicand,
	output logic        done,
	output logic [32:0] root
);
	logic [64:0] rad_q;
	logic [34:0] rem_q;
	logic [32:0] res_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [34:0] rem_sh;
	logic [34:0] trial;

	assign rem_sh = {rem_q[32:0], rad_q[64:63]};
	assign trial  = {res_q, 2'b01};
	assign root   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// resolve the top pair (bit 64 alone) at start
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= {radicand[63:0], 1'b0};
			rem_q <= '0;
			res_q <= {32'd0, radicand[64]};
		end else if (busy_q) begin
			rad_q <= {rad_q[62:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				res_q <= {res_q[31:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				res_q <= {res_q[31:0], 1'b0};
			end
		end
	end
endmodule

@@ design/wtta_cordic.sv @@
// Iterative CORDIC rotation that finds the sign of a projection on a heading.
module wtta_cordic #(
	parameter int CORDIC_STEPS = wtta_pkg::CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] dx,
	input  logic [32:0] dy,
	input  logic [15:0] head,
	output logic        done,
	output logic        forward
);
	localparam int NSTEP = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
	// 33-bit diffs * 256, plus CORDIC growth
	logic signed [43:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic [4:0] i_q;
	logic busy_q;
	logic signed [43:0] xs, ys, x0, y0;
	logic signed [33:0] z0, at;
	logic [31:0] zu;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = $signed({2'b00, wtta_pkg::atan_lut(i_q)});
	assign forward = ~x_q[43];

	always_comb begin
		zu = 32'd0 - {head, 16'd0};
		x0 = $signed({{3{dx[32]}}, dx, 8'd0});
		y0 = $signed({{3{dy[32]}}, dy, 8'd0});
		z0 = $signed({{2{zu[31]}}, zu});
		if (z0 > 34'sd1073741824 || z0 < -34'sd1073741824) begin
			x0 = -x0;
			y0 = -y0;
			z0 = (z0 > 0) ? z0 - 34'sd2147483648 : z0 + 34'sd2147483648;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			i_q    <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == 5'(NSTEP - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end
endmodule

@@ design/waypoint_travel_time_accumulator.sv @@
// Top level of the waypoint travel time accumulator.
// channel | dir | payload
// s_axis  | in  | pos_x, pos_y, heading; tuser seg_start, push_mode, plan_start
// m_axis  | out | step_time, segment_time, plan_time; tuser moved_forward, wait_added
// cfg     | in  | index, 24-bit data
// A waypoint steps through: take it, squares, start root and CORDIC, the bit-serial
// root (CORDIC runs alongside it), rate multiply, accumulate, load the result register.
// A segment start goes from taking it straight to accumulate and load. A result still
// held in the register stalls the load step, and with it s_axis_tready. Reset restores
// the control state, config, previous waypoint and totals, but not the data path.
`include "waypoint_travel_time_accumulator_assert.svh"
module waypoint_travel_time_accumulator #(
	parameter int CORDIC_STEPS = wtta_pkg::CORDIC_STEPS_DEF,
	parameter int TIME_WIDTH = wtta_pkg::TIME_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [79:0]  s_axis_tdata, // pos_x, pos_y, heading
	input  logic [2:0]   s_axis_tuser, // seg_start, push_mode, plan_start
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata, // step_time, segment_time, plan_time
	output logic [1:0]   m_axis_tuser, // moved_forward, wait_added
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [23:0]  cfg_data
);
	localparam logic [TIME_WIDTH-1:0] TMAX = '1;

	wtta_pkg::state_t st_q, st_nx;
	logic [23:0] inv_push_q, inv_tr_q, inv_rev_q, wait_q;
	logic signed [31:0] prev_x_q, prev_y_q, x_q, y_q;
	logic [15:0] prev_head_q, head_q;
	logic prev_fwd_q, seg_push_q, seg_q, plan_q;
	logic [TIME_WIDTH-1:0] seg_tot_q, plan_tot_q;
	logic signed [32:0] dx_q, dy_q;
	logic [63:0] sx_q, sy_q;
	logic [64:0] sum;
	logic [32:0] root;
	logic sq_done, cd_done, cd_fwd, root_ok_q, cd_ok_q;
	logic [32:0] dist_q;
	logic [56:0] prod_q;
	logic fwd_q, wait_b_q;
	logic [23:0] inv;
	logic [32:0] step_w;
	logic [31:0] step;
	logic [TIME_WIDTH:0] ns, np;
	logic [TIME_WIDTH-1:0] seg_base, plan_base;
	logic [63:0] seg_wide, plan_wide;
	logic accept, sq_start, load_out;
	logic [31:0] ax, ay;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign sq_start = (st_q == wtta_pkg::ST_CORDIC);
	assign load_out = (st_q == wtta_pkg::ST_OUT) && (st_nx == wtta_pkg::ST_IDLE);
	assign sum = {1'b0, sx_q} + {1'b0, sy_q};
	assign ax = dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
	assign ay = dy_q[32] ? 32'(-dy_q) : dy_q[31:0];

	wtta_sqrt u_sqrt (.clk, .arst_n, .start(sq_start), .radicand(sum),
		.done(sq_done), .root(root));
	wtta_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (.clk, .arst_n,
		.start(sq_start), .dx(dx_q), .dy(dy_q), .head(prev_head_q),
		.done(cd_done), .forward(cd_fwd));

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			wtta_pkg::ST_IDLE: if (accept) st_nx = s_axis_tuser[0] ?
				wtta_pkg::ST_ACC : wtta_pkg::ST_SQ;
			wtta_pkg::ST_SQ: st_nx = wtta_pkg::ST_CORDIC;
			wtta_pkg::ST_CORDIC: st_nx = wtta_pkg::ST_ROOT;
			wtta_pkg::ST_ROOT: if (root_ok_q && cd_ok_q) st_nx = wtta_pkg::ST_MUL;
			wtta_pkg::ST_MUL: st_nx = wtta_pkg::ST_ACC;
			wtta_pkg::ST_ACC: st_nx = wtta_pkg::ST_OUT;
			wtta_pkg::ST_OUT: if (!m_axis_tvalid || m_axis_tready) st_nx = wtta_pkg::ST_IDLE;
			default: st_nx = wtta_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (st_q == wtta_pkg::ST_IDLE);
		inv = seg_push_q ? inv_push_q : (fwd_q ? inv_tr_q : inv_rev_q);
		step_w = {1'b0, prod_q[47:16]} + (wait_b_q ? {9'd0, wait_q} : 33'd0);
		step = (prod_q[56:48] != 0 || step_w[32]) ? 32'hFFFFFFFF : step_w[31:0];
		seg_base = seg_q ? '0 : seg_tot_q;
		plan_base = plan_q ? '0 : plan_tot_q;
		ns = {1'b0, seg_base} + (TIME_WIDTH+1)'(step);
		np = {1'b0, plan_base} + (TIME_WIDTH+1)'(step);
		seg_wide = 64'(seg_tot_q);
		plan_wide = 64'(plan_tot_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= wtta_pkg::ST_IDLE;
			inv_push_q <= 24'd234057;
			inv_tr_q <= 24'd187246;
			inv_rev_q <= 24'd218453;
			wait_q <= 24'd52429;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_head_q <= '0;
			prev_fwd_q <= 1'b1;
			seg_push_q <= 1'b0;
			seg_tot_q <= '0;
			plan_tot_q <= '0;
			m_axis_tvalid <= 1'b0;
			root_ok_q <= 1'b0;
			cd_ok_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (cfg_valid) begin
				unique case (cfg_index)
					wtta_pkg::REG_PUSH: inv_push_q <= cfg_data;
					wtta_pkg::REG_TRANSIT: inv_tr_q <= cfg_data;
					wtta_pkg::REG_REVERSE: inv_rev_q <= cfg_data;
					wtta_pkg::REG_WAIT: wait_q <= cfg_data;
					default: ;
				endcase
			end
			if (load_out) m_axis_tvalid <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			if (sq_start) begin
				root_ok_q <= 1'b0;
				cd_ok_q <= 1'b0;
			end
			if (sq_done) root_ok_q <= 1'b1;
			if (cd_done) cd_ok_q <= 1'b1;
			if (st_q == wtta_pkg::ST_ACC) begin
				prev_x_q <= x_q;
				prev_y_q <= y_q;
				prev_head_q <= head_q;
				if (seg_q) begin
					seg_tot_q <= '0;
					prev_fwd_q <= 1'b1;
					seg_push_q <= fwd_q;
					plan_tot_q <= plan_base;
				end else begin
					seg_tot_q <= ns[TIME_WIDTH] ? TMAX : ns[TIME_WIDTH-1:0];
					plan_tot_q <= np[TIME_WIDTH] ? TMAX : np[TIME_WIDTH-1:0];
					if (!seg_push_q) prev_fwd_q <= fwd_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= s_axis_tdata[31:0];
			y_q <= s_axis_tdata[63:32];
			head_q <= s_axis_tdata[79:64];
			seg_q <= s_axis_tuser[0];
			plan_q <= s_axis_tuser[2];
			fwd_q <= s_axis_tuser[1];
			dx_q <= {s_axis_tdata[31], s_axis_tdata[31:0]} - {prev_x_q[31], prev_x_q};
			dy_q <= {s_axis_tdata[63], s_axis_tdata[63:32]} - {prev_y_q[31], prev_y_q};
		end
		if (st_q == wtta_pkg::ST_SQ) begin
			sx_q <= ax * ax;
			sy_q <= ay * ay;
		end
		if (st_q == wtta_pkg::ST_ROOT && root_ok_q && cd_ok_q) begin
			dist_q <= root;
			if (!seg_push_q) begin
				fwd_q <= cd_fwd;
				wait_b_q <= (cd_fwd != prev_fwd_q);
			end else begin
				fwd_q <= 1'b1;
				wait_b_q <= 1'b0;
			end
		end
		if (st_q == wtta_pkg::ST_MUL) begin
			prod_q <= dist_q * inv;
		end
		if (load_out) begin
			m_axis_tdata <= {plan_wide[47:0], seg_wide[47:0], seg_q ? 32'd0 : step};
			m_axis_tuser <= seg_q ? 2'b00 : {wait_b_q, fwd_q};
		end
	end

	`WTTA_ASSERT_NEXT(a_busy_not_ready, clk, arst_n,
		accept, !s_axis_tready)
	`WTTA_ASSERT_IMPL(a_out_hold, clk, arst_n,
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
	`WTTA_ASSERT_IMPL(a_out_stable, clk, arst_n,
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
	`WTTA_ASSERT_NEXT(a_sq_root, clk, arst_n,
		sq_start, st_q == wtta_pkg::ST_ROOT)
endmodule
